// File: rtl/risk_adaptive_power_mode_controller_defines.svh
// Assertion macros shared by the power mode controller RTL.
`ifndef RISK_ADAPTIVE_POWER_MODE_CONTROLLER_DEFINES_SVH
`define RISK_ADAPTIVE_POWER_MODE_CONTROLLER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RAPMC_ASSERT_IMPLY(name, clock, reset_n, ante, cons, msg) \
    name: assert property (@(posedge clock) disable iff (!reset_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define RAPMC_ASSERT_NEXT(name, clock, reset_n, ante, cons, msg) \
    name: assert property (@(posedge clock) disable iff (!reset_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/rapmc_pkg.sv
// Types, constants and the mode mapping function of the power mode controller.
`default_nettype none

package rapmc_pkg;

    localparam int ModeW     = 3;
    localparam int RiskW     = 12;
    localparam int IntervalW = 24;
    localparam int CountW    = 32;
    localparam int SecW      = 23;
    localparam int MsW       = 10;
    localparam int CfgIdxW   = 3;
    localparam int NumModes  = 5;

    // Power modes.
    localparam logic [ModeW-1:0] ModeSleep     = 3'd0;
    localparam logic [ModeW-1:0] ModeLow       = 3'd1;
    localparam logic [ModeW-1:0] ModeNormal    = 3'd2;
    localparam logic [ModeW-1:0] ModeHigh      = 3'd3;
    localparam logic [ModeW-1:0] ModeEmergency = 3'd4;

    // Request kinds.
    localparam logic ReqTick = 1'b0;
    localparam logic ReqRisk = 1'b1;

    // Configuration register indexes.
    localparam logic [CfgIdxW-1:0] CfgSleepInterval     = 3'd0;
    localparam logic [CfgIdxW-1:0] CfgLowInterval       = 3'd1;
    localparam logic [CfgIdxW-1:0] CfgNormalInterval    = 3'd2;
    localparam logic [CfgIdxW-1:0] CfgHighInterval      = 3'd3;
    localparam logic [CfgIdxW-1:0] CfgEmergencyInterval = 3'd4;

    // Interval reset values in milliseconds.
    localparam logic [IntervalW-1:0] SleepIntervalReset     = 24'd60000;
    localparam logic [IntervalW-1:0] LowIntervalReset       = 24'd30000;
    localparam logic [IntervalW-1:0] NormalIntervalReset    = 24'd10000;
    localparam logic [IntervalW-1:0] HighIntervalReset      = 24'd5000;
    localparam logic [IntervalW-1:0] EmergencyIntervalReset = 24'd1000;

    // Risk thresholds in Q0.12: 0.1, 0.3, 0.5 and 0.7.
    localparam logic [RiskW-1:0] ThLow       = 12'd410;
    localparam logic [RiskW-1:0] ThNormal    = 12'd1229;
    localparam logic [RiskW-1:0] ThHigh      = 12'd2048;
    localparam logic [RiskW-1:0] ThEmergency = 12'd2868;

    // The mode timer is kept as whole seconds plus milliseconds. A 32-bit
    // millisecond count of all ones is 4294967 s plus 295 ms; the next tick
    // wraps it to zero.
    localparam logic [MsW-1:0]  MsLast      = 10'd999;
    localparam logic [SecW-1:0] WrapSec     = 23'd4294967;
    localparam logic [MsW-1:0]  WrapMs      = 10'd295;

    typedef struct packed {
        logic             valid;
        logic             is_tick;
        logic             mode_change;
        logic [ModeW-1:0] old_mode;
        logic [ModeW-1:0] new_mode;
    } ctl_t;

    function automatic logic [ModeW-1:0] pick_mode(input logic [RiskW-1:0] risk);
        logic [ModeW-1:0] m;
        if (risk < ThLow) begin
            m = ModeSleep;
        end else if (risk < ThNormal) begin
            m = ModeLow;
        end else if (risk < ThHigh) begin
            m = ModeNormal;
        end else if (risk < ThEmergency) begin
            m = ModeHigh;
        end else begin
            m = ModeEmergency;
        end
        return m;
    endfunction

endpackage

`default_nettype wire

// File: rtl/rapmc_if.sv
// Handshake interfaces for the request, result and configuration channels.
`default_nettype none

interface rapmc_req_if
    import rapmc_pkg::*;
();
    logic             valid;
    logic             ready;
    logic             req_type;
    logic [RiskW-1:0] risk_level;

    modport source (output valid, output req_type, output risk_level, input ready);
    modport sink   (input valid, input req_type, input risk_level, output ready);
endinterface

interface rapmc_res_if
    import rapmc_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [ModeW-1:0]  power_mode;
    logic              mode_changed;
    logic              sample_now;
    logic [CountW-1:0] sleep_seconds;
    logic [CountW-1:0] active_seconds;
    logic [CountW-1:0] sleep_exits;
    logic [CountW-1:0] low_exits;
    logic [CountW-1:0] normal_exits;
    logic [CountW-1:0] high_exits;
    logic [CountW-1:0] emergency_exits;

    modport source (
        output valid, output power_mode, output mode_changed, output sample_now,
        output sleep_seconds, output active_seconds, output sleep_exits,
        output low_exits, output normal_exits, output high_exits,
        output emergency_exits, input ready
    );
    modport sink (
        input valid, input power_mode, input mode_changed, input sample_now,
        input sleep_seconds, input active_seconds, input sleep_exits,
        input low_exits, input normal_exits, input high_exits,
        input emergency_exits, output ready
    );
endinterface

interface rapmc_cfg_if
    import rapmc_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [CfgIdxW-1:0]   index;
    logic [IntervalW-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: rtl/rapmc_cfg_regs.sv
// Sampling interval registers and the per-mode interval select.
`default_nettype none

module rapmc_cfg_regs
    import rapmc_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    rapmc_cfg_if.sink                 cfg,
    input  wire logic [ModeW-1:0]     sel_mode,
    output logic      [IntervalW-1:0] sel_interval
);

    logic [IntervalW-1:0] sleep_iv_reg;
    logic [IntervalW-1:0] low_iv_reg;
    logic [IntervalW-1:0] normal_iv_reg;
    logic [IntervalW-1:0] high_iv_reg;
    logic [IntervalW-1:0] emergency_iv_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sleep_iv_reg     <= SleepIntervalReset;
            low_iv_reg       <= LowIntervalReset;
            normal_iv_reg    <= NormalIntervalReset;
            high_iv_reg      <= HighIntervalReset;
            emergency_iv_reg <= EmergencyIntervalReset;
        end
        else if (cfg.valid)
        begin
            // Writes to indexes past the last register are dropped.
            case (cfg.index)
                CfgSleepInterval:     sleep_iv_reg     <= cfg.data;
                CfgLowInterval:       low_iv_reg       <= cfg.data;
                CfgNormalInterval:    normal_iv_reg    <= cfg.data;
                CfgHighInterval:      high_iv_reg      <= cfg.data;
                CfgEmergencyInterval: emergency_iv_reg <= cfg.data;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (sel_mode)
            ModeSleep:     sel_interval = sleep_iv_reg;
            ModeLow:       sel_interval = low_iv_reg;
            ModeHigh:      sel_interval = high_iv_reg;
            ModeEmergency: sel_interval = emergency_iv_reg;
            default:       sel_interval = normal_iv_reg;
        endcase
    end

endmodule

`default_nettype wire

// File: rtl/rapmc_timers.sv
// Mode timer, sample timer, active interval and the sample strobe.
`default_nettype none
`include "risk_adaptive_power_mode_controller_defines.svh"

module rapmc_timers
    import rapmc_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire ctl_t                 ctl,
    input  wire logic [IntervalW-1:0] new_interval,
    output logic                      sample,
    output logic      [SecW-1:0]      mode_secs
);

    logic [MsW-1:0]       mode_ms_reg;
    logic [MsW-1:0]       mode_ms_next;
    logic [SecW-1:0]      mode_sec_reg;
    logic [SecW-1:0]      mode_sec_next;
    logic [CountW-1:0]    sample_elapsed_reg;
    logic [CountW-1:0]    sample_elapsed_next;
    logic [CountW-1:0]    sample_inc;
    logic [IntervalW-1:0] active_interval_reg;
    logic [IntervalW-1:0] active_interval_next;

    // The mode timer only ever feeds whole seconds, so it counts milliseconds
    // within the second and seconds apart, which avoids a divide by 1000.
    assign mode_secs  = mode_sec_reg;
    assign sample_inc = sample_elapsed_reg + 32'd1;
    assign sample     = ctl.is_tick
                        && (sample_inc >= {{(CountW-IntervalW){1'b0}}, active_interval_reg});

    always_comb
    begin
        mode_ms_next         = mode_ms_reg;
        mode_sec_next        = mode_sec_reg;
        sample_elapsed_next  = sample_elapsed_reg;
        active_interval_next = active_interval_reg;
        if (ctl.valid && ctl.is_tick)
        begin
            if (mode_sec_reg == WrapSec && mode_ms_reg == WrapMs)
            begin
                mode_ms_next  = '0;
                mode_sec_next = '0;
            end
            else if (mode_ms_reg == MsLast)
            begin
                mode_ms_next  = '0;
                mode_sec_next = mode_sec_reg + 23'd1;
            end
            else
            begin
                mode_ms_next = mode_ms_reg + 10'd1;
            end
            sample_elapsed_next = sample ? '0 : sample_inc;
        end
        else if (ctl.valid && ctl.mode_change)
        begin
            mode_ms_next         = '0;
            mode_sec_next        = '0;
            active_interval_next = new_interval;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_ms_reg         <= '0;
            mode_sec_reg        <= '0;
            sample_elapsed_reg  <= '0;
            active_interval_reg <= NormalIntervalReset;
        end
        else
        begin
            mode_ms_reg         <= mode_ms_next;
            mode_sec_reg        <= mode_sec_next;
            sample_elapsed_reg  <= sample_elapsed_next;
            active_interval_reg <= active_interval_next;
        end
    end

    `RAPMC_ASSERT_IMPLY(a_ms_in_range, clk, rst_n, 1'b1, mode_ms_reg <= MsLast, "ms field past 999")
    `RAPMC_ASSERT_NEXT(a_change_clears_timer, clk, rst_n, ctl.valid && ctl.mode_change, (mode_ms_reg == '0) && (mode_sec_reg == '0), "mode timer not restarted")
    `RAPMC_ASSERT_NEXT(a_sample_restarts, clk, rst_n, ctl.valid && sample, sample_elapsed_reg == '0, "sample timer not restarted")

endmodule

`default_nettype wire

// File: rtl/rapmc_stats.sv
// Exit counters and the sleep and active second totals.
`default_nettype none

module rapmc_stats
    import rapmc_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire ctl_t              ctl,
    input  wire logic [SecW-1:0]   mode_secs,
    output logic      [CountW-1:0] sleep_total,
    output logic      [CountW-1:0] active_total,
    output logic      [CountW-1:0] exits [NumModes]
);

    logic [CountW-1:0] exit_reg [NumModes];
    logic [CountW-1:0] sleep_total_reg;
    logic [CountW-1:0] active_total_reg;
    logic [CountW-1:0] secs_wide;

    assign secs_wide    = {{(CountW-SecW){1'b0}}, mode_secs};
    assign sleep_total  = sleep_total_reg;
    assign active_total = active_total_reg;

    always_comb
    begin
        for (int i = 0; i < NumModes; i++)
        begin
            exits[i] = exit_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NumModes; i++)
            begin
                exit_reg[i] <= '0;
            end
            sleep_total_reg  <= '0;
            active_total_reg <= '0;
        end
        else if (ctl.valid && ctl.mode_change)
        begin
            for (int i = 0; i < NumModes; i++)
            begin
                if (ctl.old_mode == ModeW'(i))
                begin
                    exit_reg[i] <= exit_reg[i] + 32'd1;
                end
            end
            if (ctl.old_mode == ModeSleep)
            begin
                sleep_total_reg <= sleep_total_reg + secs_wide;
            end
            else if (ctl.old_mode == ModeHigh || ctl.old_mode == ModeEmergency)
            begin
                active_total_reg <= active_total_reg + secs_wide;
            end
        end
    end

endmodule

`default_nettype wire

// File: rtl/risk_adaptive_power_mode_controller.sv
// Top level of the risk-adaptive power mode controller.
//
// Each request beat is either a one-millisecond tick or a new fire-risk value
// in Q0.12, and each one yields exactly one result beat that shows the state
// after the request: the power mode (sleep, low, normal, high, emergency,
// chosen by thresholds at 0.1, 0.3, 0.5 and 0.7), whether the request
// switched the mode, the sample strobe, the seconds spent in sleep and in
// high or emergency modes, and how often each mode was left. The block takes
// one beat per clock cycle while the sink keeps taking results: a beat is
// captured in an input register, its whole update is done by short compare
// and add logic as it leaves that register, and its result is held in the
// result register. While a result waits for the sink, one more request
// beat can still enter the input register; after that the request channel
// stalls until the sink takes the result. Interval registers are written
// through the configuration channel, which is always ready; a new interval
// takes effect at the next mode change. Reset brings the block up in normal
// mode with all counters at zero; there is no start-up sweep.
`default_nettype none
`include "risk_adaptive_power_mode_controller_defines.svh"

module risk_adaptive_power_mode_controller
    import rapmc_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    rapmc_req_if.sink  req,
    rapmc_res_if.source res,
    rapmc_cfg_if.sink  cfg
);

    // Input register.
    logic             in_valid_reg;
    logic             in_type_reg;
    logic [RiskW-1:0] in_risk_reg;

    // Mode state and result register.
    logic [ModeW-1:0] mode_reg;
    logic             out_valid_reg;
    logic             changed_reg;
    logic             sample_reg;

    logic                 advance;
    logic                 is_tick;
    logic [ModeW-1:0]     new_mode;
    logic                 change;
    logic [IntervalW-1:0] new_interval;
    logic                 sample;
    logic [SecW-1:0]      mode_secs;
    logic [CountW-1:0]    exits [NumModes];
    ctl_t                 ctl;

    // The beat in the input register moves on when the result register is
    // empty or is being emptied in this cycle.
    assign advance   = in_valid_reg && (!out_valid_reg || res.ready);
    assign req.ready = !in_valid_reg || advance;

    assign is_tick  = (in_type_reg == ReqTick);
    assign new_mode = pick_mode(in_risk_reg);
    assign change   = (in_type_reg == ReqRisk) && (new_mode != mode_reg);

    assign ctl.valid       = advance;
    assign ctl.is_tick     = is_tick;
    assign ctl.mode_change = change;
    assign ctl.old_mode    = mode_reg;
    assign ctl.new_mode    = new_mode;

    rapmc_cfg_regs u_cfg_regs (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .sel_mode     (ctl.new_mode),
        .sel_interval (new_interval)
    );

    rapmc_timers u_timers (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctl          (ctl),
        .new_interval (new_interval),
        .sample       (sample),
        .mode_secs    (mode_secs)
    );

    // The counters change only when a beat moves into the result register,
    // so they double as the result register for the statistics fields.
    rapmc_stats u_stats (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctl          (ctl),
        .mode_secs    (mode_secs),
        .sleep_total  (res.sleep_seconds),
        .active_total (res.active_seconds),
        .exits        (exits)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            mode_reg      <= ModeNormal;
        end
        else
        begin
            if (req.ready)
            begin
                in_valid_reg <= req.valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                if (change)
                begin
                    mode_reg <= new_mode;
                end
            end
            else if (res.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            in_type_reg <= req.req_type;
            in_risk_reg <= req.risk_level;
        end
        if (advance)
        begin
            changed_reg <= change;
            sample_reg  <= sample;
        end
    end

    assign res.valid           = out_valid_reg;
    assign res.power_mode      = mode_reg;
    assign res.mode_changed    = changed_reg;
    assign res.sample_now      = sample_reg;
    assign res.sleep_exits     = exits[ModeSleep];
    assign res.low_exits       = exits[ModeLow];
    assign res.normal_exits    = exits[ModeNormal];
    assign res.high_exits      = exits[ModeHigh];
    assign res.emergency_exits = exits[ModeEmergency];

    `RAPMC_ASSERT_IMPLY(a_change_or_sample, clk, rst_n, res.valid, !(res.mode_changed && res.sample_now), "mode change and sample on one beat")
    `RAPMC_ASSERT_NEXT(a_change_loads_mode, clk, rst_n, advance && change, mode_reg == $past(new_mode), "mode not taken on change")
    `RAPMC_ASSERT_NEXT(a_in_held, clk, rst_n, in_valid_reg && !advance, in_valid_reg, "stalled input beat lost")

endmodule

`default_nettype wire
